// ===== rtl/mtt_pkg.sv =====
// shared types and codes for the markup tag tokenizer
// byte classes, queue entry, result beat, role and error codes; no dependencies
package mtt_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // byte classes seen by the scanner
    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_LT,
        CLS_GT,
        CLS_SLASH,
        CLS_BANG,
        CLS_QMARK,
        CLS_EQ,
        CLS_QUOTE
    } cls_t;

    typedef enum logic [3:0] {
        ROLE_TEXT   = 4'd0,
        ROLE_DELIM  = 4'd1,
        ROLE_TNAME  = 4'd2,
        ROLE_ANAME  = 4'd3,
        ROLE_AVALUE = 4'd4,
        ROLE_COMM   = 4'd5,
        ROLE_INSTR  = 4'd6,
        ROLE_TSPACE = 4'd7,
        ROLE_NONE   = 4'd8
    } role_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_QUOTE = 3'd1,
        ERR_BOTH     = 3'd2,
        ERR_SLASH    = 3'd3,
        ERR_LT_TAG   = 3'd4,
        ERR_EOF      = 3'd5
    } err_t;

    // one classified beat in the queue
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        cls_t       cls;
    } entry_t;

    // one result beat
    typedef struct packed {
        logic [7:0] byte_out;
        role_t      role;
        logic       run_start;
        logic       text_end;
        logic       tag_begin;
        logic       begin_closed;
        logic       attribute_end;
        logic       tag_finish;
        logic       finish_closed;
        logic       comment_done;
        logic       instr_done;
        err_t       error_code;
    } result_t;

endpackage

// ===== rtl/mtt_front.sv =====
// front end: accepts input beats and classifies each byte
// depends on mtt_pkg
module mtt_front (
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            mode,
    input  logic [7:0]      byte_in,
    input  logic            q_full,
    output logic            push,
    output mtt_pkg::entry_t entry
);

    function automatic mtt_pkg::cls_t classify(input logic [7:0] b);
        mtt_pkg::cls_t c;
        unique case (b)
            8'h20, 8'h09, 8'h0d, 8'h0a: c = mtt_pkg::CLS_SPACE;
            8'h3c:                      c = mtt_pkg::CLS_LT;
            8'h3e:                      c = mtt_pkg::CLS_GT;
            8'h2f:                      c = mtt_pkg::CLS_SLASH;
            8'h21:                      c = mtt_pkg::CLS_BANG;
            8'h3f:                      c = mtt_pkg::CLS_QMARK;
            8'h3d:                      c = mtt_pkg::CLS_EQ;
            8'h22:                      c = mtt_pkg::CLS_QUOTE;
            default:                    c = mtt_pkg::CLS_OTHER;
        endcase
        return c;
    endfunction

    // accept whenever the queue has room
    assign in_ready   = !q_full;
    assign push       = in_valid && !q_full;
    assign entry.mode = mode;
    assign entry.data = byte_in;
    assign entry.cls  = classify(byte_in);

endmodule

// ===== rtl/mtt_queue.sv =====
// short queue between front and back, held in flip-flops
// depends on mtt_pkg
module mtt_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mtt_pkg::entry_t            push_entry,
    input  logic                       pop,
    output mtt_pkg::entry_t            head,
    output logic                       nonempty,
    output logic                       full,
    output logic [mtt_pkg::QCNT_W-1:0] count
);

    mtt_pkg::entry_t             store_reg [mtt_pkg::QDEPTH];
    logic [mtt_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mtt_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mtt_pkg::QCNT_W-1:0]  count_reg, count_next;

    assign head     = store_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == mtt_pkg::QCNT_W'(mtt_pkg::QDEPTH));
    assign count    = count_reg;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mtt_pkg::QPTR_W'(mtt_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mtt_pkg::QPTR_W'(mtt_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/mtt_scanner.sv =====
// back end: scan state machine and registered result beat
// depends on mtt_pkg
module mtt_scanner (
    input  logic             clk,
    input  logic             rst_n,
    input  mtt_pkg::entry_t  head,
    input  logic             nonempty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output mtt_pkg::result_t result
);

    typedef enum logic [3:0] {
        ST_TEXT, ST_LT, ST_NAME0, ST_NAME, ST_TSPACE, ST_ANAME, ST_EQ,
        ST_VALUE0, ST_VALUE, ST_SLASH, ST_COMMENT0, ST_COMMENT,
        ST_INSTR0, ST_INSTR, ST_INSTRQ
    } state_t;

    state_t           state_reg, state_next;
    logic             closing_reg, closing_next;
    logic             pending_reg, pending_next;
    mtt_pkg::err_t    sticky_reg, sticky_next;
    logic             out_valid_reg;
    mtt_pkg::result_t result_reg, r;

    logic             tspace;
    logic             is_name;
    mtt_pkg::err_t    fail_code;
    mtt_pkg::cls_t    c;

    // take a beat when the output register is free or being drained
    assign pop       = nonempty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign c       = head.cls;
    assign is_name = !(c == mtt_pkg::CLS_SPACE || c == mtt_pkg::CLS_LT ||
                       c == mtt_pkg::CLS_GT || c == mtt_pkg::CLS_SLASH);

    // next state and result for the head beat
    always_comb
    begin
        state_next   = state_reg;
        closing_next = closing_reg;
        pending_next = pending_reg;
        sticky_next  = sticky_reg;
        r            = '0;
        r.role       = mtt_pkg::ROLE_NONE;
        r.error_code = mtt_pkg::ERR_NONE;
        tspace       = 1'b0;
        fail_code    = mtt_pkg::ERR_NONE;

        if (head.mode)
        begin
            // end of document
            if (sticky_reg != mtt_pkg::ERR_NONE)
            begin
                r.error_code = sticky_reg;
            end
            else if (state_reg != ST_TEXT)
            begin
                r.error_code = mtt_pkg::ERR_EOF;
            end
            else
            begin
                r.text_end = pending_reg;
            end
            state_next   = ST_TEXT;
            closing_next = 1'b0;
            pending_next = 1'b0;
            sticky_next  = mtt_pkg::ERR_NONE;
        end
        else
        begin
            r.byte_out = head.data;
            if (sticky_reg != mtt_pkg::ERR_NONE)
            begin
                r.error_code = sticky_reg;
            end
            else
            begin
                unique case (state_reg)
                    ST_LT:
                    begin
                        if (c == mtt_pkg::CLS_SLASH)
                        begin
                            closing_next = 1'b1;
                            r.role       = mtt_pkg::ROLE_DELIM;
                            state_next   = ST_NAME0;
                        end
                        else if (c == mtt_pkg::CLS_BANG)
                        begin
                            r.role     = mtt_pkg::ROLE_DELIM;
                            state_next = ST_COMMENT0;
                        end
                        else if (c == mtt_pkg::CLS_QMARK)
                        begin
                            r.role     = mtt_pkg::ROLE_DELIM;
                            state_next = ST_INSTR0;
                        end
                        else if (is_name)
                        begin
                            r.role      = mtt_pkg::ROLE_TNAME;
                            r.run_start = 1'b1;
                            state_next  = ST_NAME;
                        end
                        else
                        begin
                            r.tag_begin = 1'b1;
                            tspace      = 1'b1;
                        end
                    end
                    ST_NAME0, ST_NAME:
                    begin
                        if (is_name)
                        begin
                            r.role      = mtt_pkg::ROLE_TNAME;
                            r.run_start = (state_reg == ST_NAME0);
                            state_next  = ST_NAME;
                        end
                        else
                        begin
                            r.tag_begin = 1'b1;
                            tspace      = 1'b1;
                        end
                    end
                    ST_TSPACE:
                    begin
                        tspace = 1'b1;
                    end
                    ST_ANAME:
                    begin
                        if (c == mtt_pkg::CLS_EQ)
                        begin
                            r.role     = mtt_pkg::ROLE_DELIM;
                            state_next = ST_EQ;
                        end
                        else if (c == mtt_pkg::CLS_LT)
                        begin
                            fail_code = mtt_pkg::ERR_LT_TAG;
                        end
                        else
                        begin
                            r.role = mtt_pkg::ROLE_ANAME;
                        end
                    end
                    ST_EQ:
                    begin
                        if (c == mtt_pkg::CLS_QUOTE)
                        begin
                            r.role     = mtt_pkg::ROLE_DELIM;
                            state_next = ST_VALUE0;
                        end
                        else
                        begin
                            fail_code = mtt_pkg::ERR_NO_QUOTE;
                        end
                    end
                    ST_VALUE0, ST_VALUE:
                    begin
                        if (c == mtt_pkg::CLS_QUOTE)
                        begin
                            r.role          = mtt_pkg::ROLE_DELIM;
                            r.attribute_end = 1'b1;
                            state_next      = ST_TSPACE;
                        end
                        else
                        begin
                            r.role      = mtt_pkg::ROLE_AVALUE;
                            r.run_start = (state_reg == ST_VALUE0);
                            state_next  = ST_VALUE;
                        end
                    end
                    ST_SLASH:
                    begin
                        if (c == mtt_pkg::CLS_GT)
                        begin
                            r.role          = mtt_pkg::ROLE_DELIM;
                            r.tag_finish    = 1'b1;
                            r.finish_closed = 1'b1;
                            state_next      = ST_TEXT;
                        end
                        else
                        begin
                            fail_code = mtt_pkg::ERR_SLASH;
                        end
                    end
                    ST_COMMENT0, ST_COMMENT:
                    begin
                        if (c == mtt_pkg::CLS_GT)
                        begin
                            r.role         = mtt_pkg::ROLE_DELIM;
                            r.comment_done = 1'b1;
                            state_next     = ST_TEXT;
                        end
                        else
                        begin
                            r.role      = mtt_pkg::ROLE_COMM;
                            r.run_start = (state_reg == ST_COMMENT0);
                            state_next  = ST_COMMENT;
                        end
                    end
                    ST_INSTRQ:
                    begin
                        if (c == mtt_pkg::CLS_GT)
                        begin
                            r.role       = mtt_pkg::ROLE_DELIM;
                            r.instr_done = 1'b1;
                            state_next   = ST_TEXT;
                        end
                        else
                        begin
                            r.role     = mtt_pkg::ROLE_INSTR;
                            state_next = (c == mtt_pkg::CLS_QMARK) ? ST_INSTRQ : ST_INSTR;
                        end
                    end
                    ST_INSTR0, ST_INSTR:
                    begin
                        r.role      = mtt_pkg::ROLE_INSTR;
                        r.run_start = (state_reg == ST_INSTR0);
                        state_next  = (c == mtt_pkg::CLS_QMARK) ? ST_INSTRQ : ST_INSTR;
                    end
                    default:
                    begin
                        // text
                        if (c == mtt_pkg::CLS_LT)
                        begin
                            r.text_end   = pending_reg;
                            pending_next = 1'b0;
                            closing_next = 1'b0;
                            r.role       = mtt_pkg::ROLE_DELIM;
                            state_next   = ST_LT;
                        end
                        else
                        begin
                            r.role       = mtt_pkg::ROLE_TEXT;
                            r.run_start  = !pending_reg;
                            pending_next = 1'b1;
                            state_next   = ST_TEXT;
                        end
                    end
                endcase

                // byte between tag name or attributes and the tag end
                if (tspace)
                begin
                    priority case (c)
                        mtt_pkg::CLS_SPACE:
                        begin
                            r.role     = mtt_pkg::ROLE_TSPACE;
                            state_next = ST_TSPACE;
                        end
                        mtt_pkg::CLS_GT:
                        begin
                            r.role       = mtt_pkg::ROLE_DELIM;
                            r.tag_finish = 1'b1;
                            state_next   = ST_TEXT;
                        end
                        mtt_pkg::CLS_SLASH:
                        begin
                            if (closing_reg)
                            begin
                                fail_code = mtt_pkg::ERR_BOTH;
                            end
                            else
                            begin
                                r.role     = mtt_pkg::ROLE_DELIM;
                                state_next = ST_SLASH;
                            end
                        end
                        mtt_pkg::CLS_LT:
                        begin
                            fail_code = mtt_pkg::ERR_LT_TAG;
                        end
                        mtt_pkg::CLS_EQ:
                        begin
                            r.role     = mtt_pkg::ROLE_DELIM;
                            state_next = ST_EQ;
                        end
                        default:
                        begin
                            r.role      = mtt_pkg::ROLE_ANAME;
                            r.run_start = 1'b1;
                            state_next  = ST_ANAME;
                        end
                    endcase
                end

                // error byte: the begin flag of a name that just ended stays
                if (fail_code != mtt_pkg::ERR_NONE)
                begin
                    sticky_next  = fail_code;
                    state_next   = ST_TEXT;
                    pending_next = 1'b0;
                    r.role       = mtt_pkg::ROLE_NONE;
                    r.error_code = fail_code;
                end

                if (r.tag_begin || r.tag_finish)
                begin
                    r.begin_closed = closing_next;
                end
            end
        end
    end

    // scan state, output valid and result beat payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TEXT;
            closing_reg   <= 1'b0;
            pending_reg   <= 1'b0;
            sticky_reg    <= mtt_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (pop)
            begin
                state_reg   <= state_next;
                closing_reg <= closing_next;
                pending_reg <= pending_next;
                sticky_reg  <= sticky_next;
                result_reg  <= r;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/markup_tag_tokenizer.sv =====
// Streaming markup tokenizer, one byte per beat at a sustained rate of one
// beat per cycle while no back-pressure holds it. Each input beat (a
// document byte, or an end-of-document beat) yields exactly one result
// beat carrying the byte's role, the event flags that complete there and
// a sticky error code that the end beat reports and clears. An accepted
// beat is written to the queue, then popped into the output register,
// where it becomes valid: the front classifies the byte into a two-entry
// queue, the back runs the scan state machine, one transition per popped
// beat, into that register. Back-pressure on the result side fills the
// queue before the input side stalls.
// depends on mtt_pkg, mtt_front, mtt_queue, mtt_scanner
module markup_tag_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic [3:0] role,
    output logic       run_start,
    output logic       text_end,
    output logic       tag_begin,
    output logic       begin_closed,
    output logic       attribute_end,
    output logic       tag_finish,
    output logic       finish_closed,
    output logic       comment_done,
    output logic       instr_done,
    output logic [2:0] error_code
);

    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_nonempty;
    logic [mtt_pkg::QCNT_W-1:0] q_count;
    mtt_pkg::entry_t            push_entry;
    mtt_pkg::entry_t            head;
    mtt_pkg::result_t           res;

    mtt_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .byte_in  (byte_in),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_entry)
    );

    mtt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .nonempty   (q_nonempty),
        .full       (q_full),
        .count      (q_count)
    );

    mtt_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .nonempty  (q_nonempty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (res)
    );

    // unpack the result beat
    assign byte_out      = res.byte_out;
    assign role          = res.role;
    assign run_start     = res.run_start;
    assign text_end      = res.text_end;
    assign tag_begin     = res.tag_begin;
    assign begin_closed  = res.begin_closed;
    assign attribute_end = res.attribute_end;
    assign tag_finish    = res.tag_finish;
    assign finish_closed = res.finish_closed;
    assign comment_done  = res.comment_done;
    assign instr_done    = res.instr_done;
    assign error_code    = res.error_code;

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= mtt_pkg::QCNT_W'(mtt_pkg::QDEPTH))
        else $error("queue count beyond depth");

    // closed-begin flag only with a begin or finish event
    a_bclosed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && begin_closed |-> tag_begin || tag_finish)
        else $error("begin_closed without tag event");

    // self-closed flag only with a finish event
    a_fclosed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finish_closed |-> tag_finish)
        else $error("finish_closed without tag_finish");

    // an input beat lands in the queue the next cycle
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> q_nonempty)
        else $error("accepted beat missing from queue");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for markup_tag_tokenizer: directed and random documents,
// per-beat token prediction and in-order comparison; depends on mtt_pkg and the rtl
module tb;

    // markup bytes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [7:0] MARKUP_CHARS [11] = '{CH_SP, CH_TAB, CH_CR, CH_LF, CH_LT, CH_GT,
                                                  CH_SLASH, CH_BANG, CH_QMARK, CH_EQ, CH_QUOTE};

    localparam int CALM_FROM = 150;
    localparam int CALM_TO   = 260;
    localparam int IDLE_PCT  = 14;

    // scanner states of the predictor
    typedef enum logic [3:0] {
        SC_TEXT, SC_LT, SC_NAME0, SC_NAME, SC_TSPACE, SC_ANAME, SC_EQ, SC_VALUE0,
        SC_VALUE, SC_SLASH, SC_COMM0, SC_COMM, SC_INSTR0, SC_INSTR, SC_INSTRQ
    } scan_st_t;

    // kinds of byte runs the generator builds
    typedef enum int {
        RUN_TEXT, RUN_TAG, RUN_ATTR, RUN_VALUE, RUN_COMMENT, RUN_INSTR
    } run_kind_t;

    // ways to break a tag
    typedef enum int {FLAW_NOQUOTE, FLAW_BOTH, FLAW_SLASH, FLAW_LT, FLAW_CUT} flaw_t;

    typedef struct {
        logic       mode;
        logic [7:0] data;
        bit         drain;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       mode = 1'b0;
    logic [7:0] byte_in = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] byte_out;
    logic [3:0] role;
    logic       run_start;
    logic       text_end;
    logic       tag_begin;
    logic       begin_closed;
    logic       attribute_end;
    logic       tag_finish;
    logic       finish_closed;
    logic       comment_done;
    logic       instr_done;
    logic [2:0] error_code;

    beat_t            doc_stream[$];
    mtt_pkg::result_t predicted_tokens[$];
    int               gen_count = 0;
    bit               hold_next = 1'b0;
    int               sent_beats = 0;
    int               seen_beats = 0;
    int               mismatches = 0;

    // predictor state
    scan_st_t      scan_st = SC_TEXT;
    logic          in_closing = 1'b0;
    logic          text_open = 1'b0;
    mtt_pkg::err_t err_hold = mtt_pkg::ERR_NONE;

    markup_tag_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .byte_in(byte_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .byte_out(byte_out), .role(role), .run_start(run_start), .text_end(text_end),
        .tag_begin(tag_begin), .begin_closed(begin_closed), .attribute_end(attribute_end),
        .tag_finish(tag_finish), .finish_closed(finish_closed), .comment_done(comment_done),
        .instr_done(instr_done), .error_code(error_code)
    );

    // ---------------- token predictor ----------------

    function automatic bit is_ws(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic bit is_name_char(input logic [7:0] b);
        return !(is_ws(b) || b == CH_LT || b == CH_GT || b == CH_SLASH);
    endfunction

    // error byte: error sticks, scanner back to text
    function automatic void fail_with(input mtt_pkg::err_t code, inout mtt_pkg::result_t r);
        err_hold = code;
        scan_st = SC_TEXT;
        text_open = 1'b0;
        r.role = mtt_pkg::ROLE_NONE;
        r.error_code = code;
    endfunction

    // byte between the tag name or attributes and the tag's end
    function automatic void tagsp_step(input logic [7:0] b, inout mtt_pkg::result_t r);
        if (is_ws(b))
            r.role = mtt_pkg::ROLE_TSPACE;
        else if (b == CH_GT)
        begin
            r.role = mtt_pkg::ROLE_DELIM;
            r.tag_finish = 1'b1;
            scan_st = SC_TEXT;
        end
        else if (b == CH_SLASH)
        begin
            if (in_closing)
                fail_with(mtt_pkg::ERR_BOTH, r);
            else
            begin
                r.role = mtt_pkg::ROLE_DELIM;
                scan_st = SC_SLASH;
            end
        end
        else if (b == CH_LT)
            fail_with(mtt_pkg::ERR_LT_TAG, r);
        else if (b == CH_EQ)
        begin
            r.role = mtt_pkg::ROLE_DELIM;
            scan_st = SC_EQ;
        end
        else
        begin
            r.role = mtt_pkg::ROLE_ANAME;
            r.run_start = 1'b1;
            scan_st = SC_ANAME;
        end
    endfunction

    function automatic void name_step(input logic [7:0] b, input bit first,
                                      inout mtt_pkg::result_t r);
        if (is_name_char(b))
        begin
            r.role = mtt_pkg::ROLE_TNAME;
            r.run_start = first;
            scan_st = SC_NAME;
        end
        else
        begin
            r.tag_begin = 1'b1;
            scan_st = SC_TSPACE;
            tagsp_step(b, r);
        end
    endfunction

    function automatic mtt_pkg::result_t predict_token(input logic m, input logic [7:0] b);
        mtt_pkg::result_t r;
        r = '0;
        r.role = mtt_pkg::ROLE_NONE;
        if (m)
        begin
            // end of document: report and clear
            if (err_hold != mtt_pkg::ERR_NONE)
                r.error_code = err_hold;
            else if (scan_st != SC_TEXT)
                r.error_code = mtt_pkg::ERR_EOF;
            else
                r.text_end = text_open;
            scan_st = SC_TEXT;
            in_closing = 1'b0;
            text_open = 1'b0;
            err_hold = mtt_pkg::ERR_NONE;
        end
        else
        begin
            r.byte_out = b;
            if (err_hold != mtt_pkg::ERR_NONE)
                r.error_code = err_hold;
            else
            begin
                case (scan_st)
                    SC_LT:
                    begin
                        if (b == CH_SLASH)
                        begin
                            in_closing = 1'b1;
                            r.role = mtt_pkg::ROLE_DELIM;
                            scan_st = SC_NAME0;
                        end
                        else if (b == CH_BANG)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            scan_st = SC_COMM0;
                        end
                        else if (b == CH_QMARK)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            scan_st = SC_INSTR0;
                        end
                        else
                            name_step(b, 1'b1, r);
                    end
                    SC_NAME0:  name_step(b, 1'b1, r);
                    SC_NAME:   name_step(b, 1'b0, r);
                    SC_TSPACE: tagsp_step(b, r);
                    SC_ANAME:
                    begin
                        if (b == CH_EQ)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            scan_st = SC_EQ;
                        end
                        else if (b == CH_LT)
                            fail_with(mtt_pkg::ERR_LT_TAG, r);
                        else
                            r.role = mtt_pkg::ROLE_ANAME;
                    end
                    SC_EQ:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            scan_st = SC_VALUE0;
                        end
                        else
                            fail_with(mtt_pkg::ERR_NO_QUOTE, r);
                    end
                    SC_VALUE0, SC_VALUE:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            r.attribute_end = 1'b1;
                            scan_st = SC_TSPACE;
                        end
                        else
                        begin
                            r.role = mtt_pkg::ROLE_AVALUE;
                            r.run_start = (scan_st == SC_VALUE0);
                            scan_st = SC_VALUE;
                        end
                    end
                    SC_SLASH:
                    begin
                        if (b == CH_GT)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            r.tag_finish = 1'b1;
                            r.finish_closed = 1'b1;
                            scan_st = SC_TEXT;
                        end
                        else
                            fail_with(mtt_pkg::ERR_SLASH, r);
                    end
                    SC_COMM0, SC_COMM:
                    begin
                        if (b == CH_GT)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            r.comment_done = 1'b1;
                            scan_st = SC_TEXT;
                        end
                        else
                        begin
                            r.role = mtt_pkg::ROLE_COMM;
                            r.run_start = (scan_st == SC_COMM0);
                            scan_st = SC_COMM;
                        end
                    end
                    SC_INSTRQ:
                    begin
                        // only '?>' closes an instruction
                        if (b == CH_GT)
                        begin
                            r.role = mtt_pkg::ROLE_DELIM;
                            r.instr_done = 1'b1;
                            scan_st = SC_TEXT;
                        end
                        else
                        begin
                            r.role = mtt_pkg::ROLE_INSTR;
                            scan_st = (b == CH_QMARK) ? SC_INSTRQ : SC_INSTR;
                        end
                    end
                    SC_INSTR0, SC_INSTR:
                    begin
                        r.role = mtt_pkg::ROLE_INSTR;
                        r.run_start = (scan_st == SC_INSTR0);
                        scan_st = (b == CH_QMARK) ? SC_INSTRQ : SC_INSTR;
                    end
                    default:
                    begin
                        if (b == CH_LT)
                        begin
                            r.text_end = text_open;
                            text_open = 1'b0;
                            in_closing = 1'b0;
                            r.role = mtt_pkg::ROLE_DELIM;
                            scan_st = SC_LT;
                        end
                        else
                        begin
                            r.role = mtt_pkg::ROLE_TEXT;
                            r.run_start = !text_open;
                            text_open = 1'b1;
                            scan_st = SC_TEXT;
                        end
                    end
                endcase
                if (r.tag_begin || r.tag_finish)
                    r.begin_closed = in_closing;
            end
        end
        return r;
    endfunction

    function automatic string fmt_token(input mtt_pkg::result_t t);
        return $sformatf({"byte=%h role=%0d run=%b tend=%b begin=%b bcl=%b attr=%b ",
                          "fin=%b fcl=%b cmt=%b ins=%b err=%0d"},
                         t.byte_out, t.role, t.run_start, t.text_end, t.tag_begin,
                         t.begin_closed, t.attribute_end, t.tag_finish, t.finish_closed,
                         t.comment_done, t.instr_done, t.error_code);
    endfunction

    // ---------------- document generator ----------------

    task automatic push_byte(input logic [7:0] b);
        doc_stream.push_back('{mode: 1'b0, data: b, drain: hold_next});
        hold_next = 1'b0;
        gen_count++;
    endtask

    task automatic push_end(input logic [7:0] b);
        doc_stream.push_back('{mode: 1'b1, data: b, drain: hold_next});
        hold_next = 1'b0;
        gen_count++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // half markup characters, half anything
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 1))
            return MARKUP_CHARS[$urandom_range(0, 10)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_for(input run_kind_t kind);
        logic [7:0] b;
        bit ok;
        do
        begin
            b = pick_byte();
            case (kind)
                RUN_TEXT:  ok = (b != CH_LT);
                RUN_TAG:   ok = is_name_char(b) && b != CH_BANG && b != CH_QMARK;
                RUN_ATTR:  ok = is_name_char(b) && b != CH_EQ;
                RUN_VALUE: ok = (b != CH_QUOTE);
                default:   ok = (b != CH_GT);
            endcase
        end
        while (!ok);
        return b;
    endfunction

    function automatic logic [7:0] pick_ws();
        return MARKUP_CHARS[$urandom_range(0, 3)];
    endfunction

    // one tag, well formed unless a flaw is asked for
    task automatic gen_tag(input bit bad);
        bit    closing;
        flaw_t flaw;
        logic [7:0] b;
        closing = ($urandom_range(0, 3) == 0);
        flaw = flaw_t'($urandom_range(0, 4));
        if (bad && flaw == FLAW_BOTH)
            closing = 1'b1;
        if (bad && flaw == FLAW_SLASH)
            closing = 1'b0;
        push_byte(CH_LT);
        if (closing)
            push_byte(CH_SLASH);
        repeat ($urandom_range(0, 3))
            push_byte(pick_for(RUN_TAG));
        if (bad)
        begin
            case (flaw)
                FLAW_NOQUOTE:
                begin
                    push_byte(pick_ws());
                    push_byte(CH_EQ);
                    do b = pick_byte(); while (b == CH_QUOTE);
                    push_byte(b);
                end
                FLAW_BOTH:
                    push_byte(CH_SLASH);
                FLAW_SLASH:
                begin
                    push_byte(pick_ws());
                    push_byte(CH_SLASH);
                    do b = pick_byte(); while (b == CH_GT);
                    push_byte(b);
                end
                FLAW_LT:
                begin
                    push_byte(pick_ws());
                    push_byte(CH_LT);
                end
                default: ;
            endcase
            return;
        end
        repeat ($urandom_range(0, 2))
        begin
            repeat ($urandom_range(1, 2))
                push_byte(pick_ws());
            repeat ($urandom_range(0, 3))
                push_byte(pick_for(RUN_ATTR));
            push_byte(CH_EQ);
            push_byte(CH_QUOTE);
            repeat ($urandom_range(0, 4))
                push_byte(pick_for(RUN_VALUE));
            push_byte(CH_QUOTE);
        end
        if ($urandom_range(0, 1))
            push_byte(pick_ws());
        if (!closing && $urandom_range(0, 2) == 0)
            push_byte(CH_SLASH);
        push_byte(CH_GT);
    endtask

    // a document of mixed content; a bad one ends at its broken tag
    task automatic gen_doc(input bit bad);
        int n;
        int bad_at;
        n = $urandom_range(1, 6);
        bad_at = bad ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < n; i++)
        begin
            if (i == bad_at)
            begin
                gen_tag(1'b1);
                break;
            end
            case ($urandom_range(0, 5))
                0, 1:
                    repeat ($urandom_range(1, 5))
                        push_byte(pick_for(RUN_TEXT));
                2, 3:
                    gen_tag(1'b0);
                4:
                begin
                    push_byte(CH_LT);
                    push_byte(CH_BANG);
                    repeat ($urandom_range(0, 4))
                        push_byte(pick_for(RUN_COMMENT));
                    push_byte(CH_GT);
                end
                default:
                begin
                    push_byte(CH_LT);
                    push_byte(CH_QMARK);
                    repeat ($urandom_range(0, 4))
                        push_byte(pick_for(RUN_INSTR));
                    push_byte(CH_QMARK);
                    push_byte(CH_GT);
                end
            endcase
        end
        push_end(8'($urandom_range(0, 255)));
    endtask

    // ---------------- clock, reset, stimulus ----------------

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        bit held_once;
        int roll;
        held_once = 1'b0;

        // directed: extreme bytes, attribute, self-close, empty closing tag,
        // comment, instruction with '?' inside, end item, end inside markup
        push_byte(8'hFF);
        push_str("<a =\"");
        push_byte(8'h00);
        push_str("\"/></><!c><??x?>");
        push_end(8'hFF);
        push_str("<");
        push_end(8'h00);

        // random documents
        while (gen_count < 425)
        begin
            if (!held_once && gen_count > 120)
            begin
                hold_next = 1'b1;
                held_once = 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
                hold_next = 1'b1;
            roll = $urandom_range(0, 9);
            if (roll < 7)
                gen_doc(1'b0);
            else if (roll < 9)
                gen_doc(1'b1);
            else
            begin
                repeat ($urandom_range(3, 15))
                    push_byte(pick_byte());
                push_end(8'($urandom_range(0, 255)));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // drain and settle
        wait (doc_stream.size() == 0 && !in_valid);
        wait (sent_beats == seen_beats);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && predicted_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge clk)
    begin : driver
        bit    fire;
        beat_t nxt;
        if (rst_n)
        begin
            // beat taken: predict its token
            if (in_valid && in_ready)
            begin
                predicted_tokens.push_back(predict_token(mode, byte_in));
                sent_beats++;
            end
            if (!in_valid || in_ready)
            begin
                fire = 1'b0;
                if (doc_stream.size() != 0)
                begin
                    if (doc_stream[0].drain && sent_beats != seen_beats)
                        fire = 1'b0;
                    else if (!(sent_beats >= CALM_FROM && sent_beats < CALM_TO)
                             && $urandom_range(0, 99) < IDLE_PCT)
                        fire = 1'b0;
                    else
                        fire = 1'b1;
                end
                if (fire)
                begin
                    nxt = doc_stream.pop_front();
                    in_valid <= 1'b1;
                    mode <= nxt.mode;
                    byte_in <= nxt.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin : monitor
        mtt_pkg::result_t got;
        mtt_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.byte_out = byte_out;
                got.role = mtt_pkg::role_t'(role);
                got.run_start = run_start;
                got.text_end = text_end;
                got.tag_begin = tag_begin;
                got.begin_closed = begin_closed;
                got.attribute_end = attribute_end;
                got.tag_finish = tag_finish;
                got.finish_closed = finish_closed;
                got.comment_done = comment_done;
                got.instr_done = instr_done;
                got.error_code = mtt_pkg::err_t'(error_code);
                if (predicted_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token beat %0d: %s", seen_beats, fmt_token(got));
                end
                else
                begin
                    want = predicted_tokens.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("token beat %0d mismatch", seen_beats);
                            $display("  expected %s", fmt_token(want));
                            $display("  actual   %s", fmt_token(got));
                        end
                    end
                end
                seen_beats <= seen_beats + 1;
            end
            // receiver stalls, none inside the calm window
            out_ready <= (seen_beats >= CALM_FROM && seen_beats < CALM_TO)
                         || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

endmodule

// ===== sim.f =====
rtl/mtt_pkg.sv
rtl/mtt_front.sv
rtl/mtt_queue.sv
rtl/mtt_scanner.sv
rtl/markup_tag_tokenizer.sv
tb/tb.sv
